FILE: hdl/cltok_pkg.sv
// Shared types and constants for the command line tokenizer.
// Byte codes, token kinds, phase encoding and the result beat layout.
// No dependencies.
package cltok_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_PATH  = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_CMD    = 7'b0000001,
    PH_PSTART = 7'b0000010,
    PH_PARAM  = 7'b0000100,
    PH_QUOTED = 7'b0001000,
    PH_SKIP   = 7'b0010000,
    PH_QSTART = 7'b0100000,
    PH_PLAIN  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       line_end;
    logic       quote_error;
  } result_t;

endpackage

FILE: hdl/cltok_byte_if.sv
// Input channel of the command line tokenizer: one line byte per beat.
// Valid/ready handshake; no dependencies.
interface cltok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_line;

  modport source (output valid, output in_char, output end_of_line, input ready);
  modport sink   (input valid, input in_char, input end_of_line, output ready);
endinterface

FILE: hdl/cltok_token_if.sv
// Output channel of the command line tokenizer: one classified byte per beat.
// Valid/ready handshake; no dependencies.
interface cltok_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_end;
  logic       line_end;
  logic       quote_error;

  modport source (output valid, output token_kind, output out_char, output char_valid,
                  output token_end, output line_end, output quote_error, input ready);
  modport sink   (input valid, input token_kind, input out_char, input char_valid,
                  input token_end, input line_end, input quote_error, output ready);
endinterface

FILE: hdl/command_line_tokenizer.sv
// Command line tokenizer top level: phase machine, output register and skid stage.
// Depends on cltok_pkg, cltok_byte_if and cltok_token_if.
//
//   channel   modport          payload
//   bytes     sink             in_char, end_of_line
//   tokens    source           token_kind, out_char, char_valid, token_end,
//                              line_end, quote_error
//
// One byte per cycle unless the skid stage is full; result beats are registered.
// The phase machine classifies each byte in the cycle it is accepted.
// bytes.ready comes from the skid stage only: it drops once a stall on tokens
// catches a second beat and stays low until tokens takes the waiting beat.
// rst (synchronous) returns the phase to the command name and empties both stages.
module command_line_tokenizer (
  input  logic clk,
  input  logic rst,
  cltok_byte_if.sink    bytes,
  cltok_token_if.source tokens
);

  cltok_pkg::phase_t  phase;
  cltok_pkg::phase_t  phase_next;
  cltok_pkg::result_t res;
  cltok_pkg::result_t out_reg;
  cltok_pkg::result_t skid_reg;
  logic               has_res;
  logic               out_valid;
  logic               skid_valid;
  logic               accept;
  logic               pop;
  logic [7:0]         b;
  logic               eol;

  assign bytes.ready = !skid_valid;
  assign accept      = bytes.valid && !skid_valid;
  assign pop         = out_valid && tokens.ready;
  assign b           = bytes.in_char;
  assign eol         = bytes.end_of_line;

  always_comb begin
    phase_next      = phase;
    has_res         = 1'b0;
    res.token_kind  = cltok_pkg::KIND_PATH;
    res.out_char    = 8'd0;
    res.char_valid  = 1'b0;
    res.token_end   = 1'b0;
    res.line_end    = 1'b0;
    res.quote_error = 1'b0;
    unique case (phase)
      cltok_pkg::PH_PSTART, cltok_pkg::PH_QSTART, cltok_pkg::PH_PLAIN: begin
        if (phase == cltok_pkg::PH_PSTART && b == cltok_pkg::CH_SLASH && !eol) begin
          phase_next     = cltok_pkg::PH_PARAM;
          has_res        = 1'b1;
          res.token_kind = cltok_pkg::KIND_PARAM;
          res.out_char   = b;
          res.char_valid = 1'b1;
        end else if (phase != cltok_pkg::PH_PLAIN && b == cltok_pkg::CH_QUOTE) begin
          if (eol) begin
            has_res         = 1'b1;
            res.line_end    = 1'b1;
            res.quote_error = 1'b1;
          end else begin
            phase_next = cltok_pkg::PH_QUOTED;
          end
        end else begin
          phase_next = cltok_pkg::PH_PLAIN;
          has_res    = 1'b1;
          if (b == cltok_pkg::CH_SPACE) begin
            res.token_end = 1'b1;
            res.line_end  = eol;
          end else begin
            res.out_char   = b;
            res.char_valid = 1'b1;
            res.token_end  = eol;
            res.line_end   = eol;
          end
        end
      end
      cltok_pkg::PH_QUOTED: begin
        has_res = 1'b1;
        if (b == cltok_pkg::CH_QUOTE) begin
          phase_next    = cltok_pkg::PH_SKIP;
          res.token_end = 1'b1;
          res.line_end  = eol;
        end else if (eol) begin
          res.line_end    = 1'b1;
          res.quote_error = 1'b1;
        end else begin
          res.out_char   = b;
          res.char_valid = 1'b1;
        end
      end
      cltok_pkg::PH_SKIP: begin
        phase_next   = cltok_pkg::PH_QSTART;
        has_res      = eol;
        res.line_end = 1'b1;
      end
      default: begin
        phase_next     = (phase == cltok_pkg::PH_PARAM) ? cltok_pkg::PH_PARAM
                                                        : cltok_pkg::PH_CMD;
        has_res        = 1'b1;
        res.token_kind = (phase == cltok_pkg::PH_PARAM) ? cltok_pkg::KIND_PARAM
                                                        : cltok_pkg::KIND_CMD;
        if (b == cltok_pkg::CH_SPACE) begin
          phase_next    = cltok_pkg::PH_PSTART;
          res.token_end = 1'b1;
          res.line_end  = eol;
        end else begin
          res.out_char   = b;
          res.char_valid = 1'b1;
          res.token_end  = eol;
          res.line_end   = eol;
        end
      end
    endcase
    if (eol) begin
      phase_next = cltok_pkg::PH_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cltok_pkg::PH_CMD;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // hold a beat in the skid stage while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (accept && has_res) begin
      if (out_valid && !pop) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end else begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.token_kind  = out_reg.token_kind;
  assign tokens.out_char    = out_reg.out_char;
  assign tokens.char_valid  = out_reg.char_valid;
  assign tokens.token_end   = out_reg.token_end;
  assign tokens.line_end    = out_reg.line_end;
  assign tokens.quote_error = out_reg.quote_error;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the output register is empty");

  a_eol_resets_phase: assert property (@(posedge clk) disable iff (rst)
    accept && eol |=> phase == cltok_pkg::PH_CMD)
    else $error("phase not back at command name after end of line");

  a_error_ends_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.quote_error |-> out_reg.line_end && !out_reg.char_valid
                                         && !out_reg.token_end)
    else $error("quote error beat without line end or with a byte");

endmodule

FILE: test/tb_top.sv
// Testbench for command_line_tokenizer: directed stimulus table, then random lines.
// Depends on cltok_pkg, cltok_byte_if, cltok_token_if and the tokenizer top level.
// Expected beats: typed table rows or a phase predictor; bursts of idling stress both channels.
module tb_top;

  localparam int N_ITEMS = 1150;
  localparam int CALM_ITEMS = 150;
  localparam int MAX_PRINTED = 50;

  localparam logic [7:0] SLASH = cltok_pkg::CH_SLASH;
  localparam logic [7:0] QUOTE = cltok_pkg::CH_QUOTE;
  localparam logic [7:0] SPACE = cltok_pkg::CH_SPACE;

  typedef struct packed {
    logic [7:0]         ch;
    logic               eol;
    logic               typed;
    cltok_pkg::result_t want;
  } row_t;

  localparam cltok_pkg::result_t NO_BEAT = '0;
  localparam int N_DIRECTED = 29;
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, '{cltok_pkg::KIND_CMD,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{cltok_pkg::KIND_CMD,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{SPACE, 1'b0, 1'b1, '{cltok_pkg::KIND_CMD,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{SLASH, 1'b0, 1'b1, '{cltok_pkg::KIND_PARAM, SLASH, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h70, 1'b0, 1'b0, NO_BEAT},
    '{SPACE, 1'b0, 1'b1, '{cltok_pkg::KIND_PARAM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{8'h71, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{8'h78, 1'b0, 1'b0, NO_BEAT},
    '{8'h79, 1'b0, 1'b0, NO_BEAT},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{SPACE, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{8'h63, 1'b0, 1'b0, NO_BEAT},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{SLASH, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  SLASH, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{8'h7A, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{SPACE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{QUOTE, 1'b0, 1'b0, NO_BEAT},
    '{8'h6B, 1'b1, 1'b1, '{cltok_pkg::KIND_PATH,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{8'h41, 1'b1, 1'b1, '{cltok_pkg::KIND_CMD,   8'h41, 1'b1, 1'b1, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  cltok_byte_if  bytes_ch ();
  cltok_token_if tokens_ch ();

  command_line_tokenizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch.sink),
    .tokens (tokens_ch.source)
  );

  cltok_pkg::phase_t  tok_phase = cltok_pkg::PH_CMD;
  cltok_pkg::result_t pending_beats [$];
  logic [7:0]         line_bytes [$];
  int                 mismatch_count = 0;
  int                 items_sent = 0;
  int                 gap_level = 0;
  int                 stall_level = 1;
  bit                 calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic cltok_pkg::result_t make_beat(cltok_pkg::kind_t kind, logic [7:0] ch,
                                                   logic cv, logic te, logic le, logic qe);
    cltok_pkg::result_t beat;
    beat.token_kind  = kind;
    beat.out_char    = ch;
    beat.char_valid  = cv;
    beat.token_end   = te;
    beat.line_end    = le;
    beat.quote_error = qe;
    return beat;
  endfunction

  function automatic cltok_pkg::result_t plain_byte(logic [7:0] ch, logic eol);
    tok_phase = cltok_pkg::PH_PLAIN;
    if (ch == SPACE) return make_beat(cltok_pkg::KIND_PATH, 8'h00, 1'b0, 1'b1, eol, 1'b0);
    return make_beat(cltok_pkg::KIND_PATH, ch, 1'b1, eol, eol, 1'b0);
  endfunction

  function automatic bit open_quote(logic eol, output cltok_pkg::result_t beat);
    beat = make_beat(cltok_pkg::KIND_PATH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    if (!eol) begin
      tok_phase = cltok_pkg::PH_QUOTED;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cltok_pkg::result_t word_byte(cltok_pkg::kind_t kind, logic [7:0] ch,
                                                   logic eol);
    if (ch == SPACE) begin
      tok_phase = cltok_pkg::PH_PSTART;
      return make_beat(kind, 8'h00, 1'b0, 1'b1, eol, 1'b0);
    end
    return make_beat(kind, ch, 1'b1, eol, eol, 1'b0);
  endfunction

  function automatic bit classify_byte(logic [7:0] ch, logic eol,
                                       output cltok_pkg::result_t beat);
    bit emits;
    emits = 1'b1;
    beat = NO_BEAT;
    case (tok_phase)
      cltok_pkg::PH_PSTART: begin
        if (ch == SLASH && !eol) begin
          tok_phase = cltok_pkg::PH_PARAM;
          beat = make_beat(cltok_pkg::KIND_PARAM, ch, 1'b1, 1'b0, 1'b0, 1'b0);
        end else if (ch == QUOTE) begin
          emits = open_quote(eol, beat);
        end else begin
          beat = plain_byte(ch, eol);
        end
      end
      cltok_pkg::PH_PARAM: beat = word_byte(cltok_pkg::KIND_PARAM, ch, eol);
      cltok_pkg::PH_QUOTED: begin
        if (ch == QUOTE) begin
          tok_phase = cltok_pkg::PH_SKIP;
          beat = make_beat(cltok_pkg::KIND_PATH, 8'h00, 1'b0, 1'b1, eol, 1'b0);
        end else if (eol) begin
          beat = make_beat(cltok_pkg::KIND_PATH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          beat = make_beat(cltok_pkg::KIND_PATH, ch, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      cltok_pkg::PH_SKIP: begin
        tok_phase = cltok_pkg::PH_QSTART;
        emits = eol;
        beat = make_beat(cltok_pkg::KIND_PATH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      end
      cltok_pkg::PH_QSTART: begin
        if (ch == QUOTE) emits = open_quote(eol, beat);
        else beat = plain_byte(ch, eol);
      end
      cltok_pkg::PH_PLAIN: beat = plain_byte(ch, eol);
      default: begin
        tok_phase = cltok_pkg::PH_CMD;
        beat = word_byte(cltok_pkg::KIND_CMD, ch, eol);
      end
    endcase
    if (eol) tok_phase = cltok_pkg::PH_CMD;
    return emits;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    cltok_pkg::result_t got;
    cltok_pkg::result_t want;
    if (!rst && tokens_ch.valid && tokens_ch.ready) begin
      got = make_beat(cltok_pkg::kind_t'(tokens_ch.token_kind), tokens_ch.out_char,
                      tokens_ch.char_valid, tokens_ch.token_end, tokens_ch.line_end,
                      tokens_ch.quote_error);
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected token beat %h", got));
      end else begin
        want = pending_beats.pop_front();
        check_field("token_kind", got.token_kind, want.token_kind);
        check_field("out_char", got.out_char, want.out_char);
        check_field("char_valid", got.char_valid, want.char_valid);
        check_field("token_end", got.token_end, want.token_end);
        check_field("line_end", got.line_end, want.line_end);
        check_field("quote_error", got.quote_error, want.quote_error);
      end
    end
  end

  initial begin
    tokens_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (!calm && stall_level > 0 && $urandom_range(0, 15) < stall_level) begin
        tokens_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      tokens_ch.ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) stall_level = $urandom_range(0, 3);
      @(negedge clk);
    end
  end

  task automatic send_beat(logic [7:0] ch, logic eol, logic typed, cltok_pkg::result_t want);
    cltok_pkg::result_t beat;
    if (!calm && gap_level > 0 && $urandom_range(0, 9) < gap_level) begin
      bytes_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    bytes_ch.valid       <= 1'b1;
    bytes_ch.in_char     <= ch;
    bytes_ch.end_of_line <= eol;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    if (classify_byte(ch, eol, beat)) pending_beats.push_back(typed ? want : beat);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    bytes_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_beats.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(8'h61, 8'h7A));
    if ($urandom_range(0, 5) == 0) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic build_line();
    int cut;
    line_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 3))
          0: line_bytes.push_back(SPACE);
          1: line_bytes.push_back(QUOTE);
          2: line_bytes.push_back(SLASH);
          default: line_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    repeat ($urandom_range(1, 5)) line_bytes.push_back(pick_byte());
    repeat ($urandom_range(0, 5)) begin
      line_bytes.push_back(SPACE);
      case ($urandom_range(0, 3))
        0: begin
          line_bytes.push_back(SLASH);
          repeat ($urandom_range(0, 4)) line_bytes.push_back(pick_byte());
        end
        1: begin
          line_bytes.push_back(QUOTE);
          repeat ($urandom_range(0, 5))
            line_bytes.push_back($urandom_range(0, 3) == 0 ? SPACE : pick_byte());
          if ($urandom_range(0, 5) != 0) line_bytes.push_back(QUOTE);
        end
        2: repeat ($urandom_range(1, 4)) line_bytes.push_back(pick_byte());
        default: ;
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(0, line_bytes.size() - 1);
      line_bytes = line_bytes[0:cut];
    end
  endtask

  initial begin
    bit paused;
    int drain_cycles;
    paused = 1'b0;
    drain_cycles = 0;
    bytes_ch.valid       = 1'b0;
    bytes_ch.in_char     = 8'h00;
    bytes_ch.end_of_line = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_level = 2;
    for (int i = 0; i < N_DIRECTED; i++)
      send_beat(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].eol, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    hold_until_drained();

    while (items_sent < N_ITEMS) begin
      build_line();
      gap_level = $urandom_range(0, 3);
      if (items_sent > N_ITEMS - CALM_ITEMS) calm = 1'b1;
      foreach (line_bytes[i])
        send_beat(line_bytes[i], i == line_bytes.size() - 1, 1'b0, NO_BEAT);
      if (!paused && items_sent > N_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    bytes_ch.valid <= 1'b0;

    while (pending_beats.size() != 0 && drain_cycles < 2000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (20) @(negedge clk);
    if (pending_beats.size() != 0)
      report_mismatch($sformatf("%0d token beats never arrived", pending_beats.size()));

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: command_line_tokenizer.f
hdl/cltok_pkg.sv
hdl/cltok_byte_if.sv
hdl/cltok_token_if.sv
hdl/command_line_tokenizer.sv
test/tb_top.sv
